### src/drc_pkg.sv
// drc_pkg: shared types, constants and command codes for the dirty rectangle coalescer
// no dependencies
package drc_pkg;

  localparam int unsigned MaxRects   = 16;
  localparam int unsigned CoordBits  = 14;
  localparam int unsigned IdxBits    = $clog2(MaxRects);
  localparam int unsigned CntBits    = $clog2(MaxRects + 1);
  localparam int unsigned WasteBits  = 28;
  localparam int unsigned AreaBits   = 2 * CoordBits;
  localparam int unsigned RectBits   = 4 * CoordBits;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdAdd   = 2'd1,
    CmdRead  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef struct packed {
    logic [1:0] command;
    coord_t     new_left;
    coord_t     new_top;
    coord_t     new_right;
    coord_t     new_bottom;
  } in_item_t;

  typedef struct packed {
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
    logic   entry_valid;
    logic   last_entry;
    coord_t union_left;
    coord_t union_top;
    coord_t union_right;
    coord_t union_bottom;
    logic   overflowed;
  } out_item_t;

  // controller to datapath
  typedef enum logic [2:0] {
    DpIdle    = 3'd0,
    DpLoad    = 3'd1,  // capture new rectangle, reset scan index and union
    DpScan    = 3'd2,  // evaluate entry at scan index
    DpShift   = 3'd3,  // move entry down by one during removal
    DpAppend  = 3'd4,  // write result at tail or merge
    DpUnion   = 3'd5,  // accumulate global union
    DpEmit    = 3'd6,  // fetch entry for output
    DpClear   = 3'd7
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   take;  // output register takes the fetched entry
  } dp_cmd_t;

  typedef struct packed {
    logic absorb;     // stored entry at index merges with current
    logic idx_at_end; // index reached entry count
    logic shift_done; // removal shift finished
    logic rd_valid;   // registered read data from memory available
    logic empty;      // entry count is zero
    logic emit_last;  // entry being emitted is the last one
    logic full;       // entry count at capacity
  } dp_sts_t;

  function automatic logic box_empty(box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic box_t box_union(box_t a, box_t b);
    box_t u;
    logic ea;
    logic eb;
    ea = box_empty(a);
    eb = box_empty(b);
    u  = '0;
    if (ea && eb) begin
      u = '0;
    end else if (ea) begin
      u = b;
    end else if (eb) begin
      u = a;
    end else begin
      u.l = (a.l < b.l) ? a.l : b.l;
      u.t = (a.t < b.t) ? a.t : b.t;
      u.r = (a.r > b.r) ? a.r : b.r;
      u.b = (a.b > b.b) ? a.b : b.b;
    end
    return u;
  endfunction

  function automatic logic box_overlap(box_t a, box_t b);
    return !box_empty(a) && !box_empty(b) &&
           (a.l < b.r) && (b.l < a.r) && (a.t < b.b) && (b.t < a.b);
  endfunction

endpackage

### src/drc_ram.sv
// drc_ram: generic single-port-write, single-read ram with registered read
// no dependencies
module drc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/drc_datapath.sv
// drc_datapath: rectangle store, scan index, merge test and union registers
// depends on drc_pkg and drc_ram
module drc_datapath
  import drc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WasteBits-1:0] waste_limit_i,
  input  in_item_t             in_item_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output out_item_t            out_item_o
);
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] idx_q, idx_d;
  logic               ovf_q, ovf_d;
  box_t               cur_q, cur_d;
  box_t               all_q, all_d;
  logic               rdv_q, rdv_d;
  // pipelined merge test: stage 1 registers areas
  logic [AreaBits-1:0] a_cur_q, a_sto_q, a_uni_q;
  logic                ovl_q;
  logic                tst_q, tst_d;

  logic               we;
  logic [IdxBits-1:0] waddr, raddr;
  box_t               wdata, rdata;

  drc_ram #(.Width(RectBits), .Depth(MaxRects)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [AreaBits-1:0] area(box_t a);
    coord_t w;
    coord_t h;
    w = a.r - a.l;
    h = a.b - a.t;
    return box_empty(a) ? '0 : AreaBits'(w * h);
  endfunction

  box_t                rd_uni;
  logic [AreaBits+1:0] waste_rhs;
  assign rd_uni = box_union(cur_q, rdata);
  // union minus both areas <= limit, rearranged to avoid sign handling
  assign waste_rhs = (AreaBits+2)'(a_cur_q) + (AreaBits+2)'(a_sto_q)
                   + (AreaBits+2)'(waste_limit_i);

  always_ff @(posedge clk_i) begin
    a_cur_q <= area(cur_q);
    a_sto_q <= area(rdata);
    a_uni_q <= area(rd_uni);
    ovl_q   <= box_overlap(cur_q, rdata);
  end

  logic absorb;
  assign absorb = ovl_q || ((AreaBits+2)'(a_uni_q) <= waste_rhs);

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    cur_d   = cur_q;
    all_d   = all_q;
    rdv_d   = 1'b0;
    tst_d   = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[IdxBits-1:0];
    wdata   = rdata;
    raddr   = idx_q[IdxBits-1:0];
    case (cmd_i.op)
      DpClear: begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
      DpLoad: begin
        cur_d = '{l: in_item_i.new_left, t: in_item_i.new_top,
                  r: in_item_i.new_right, b: in_item_i.new_bottom};
        all_d = '0;
        idx_d = '0;
      end
      DpScan: begin
        // three phases: read issued, data valid, test registered
        if (!rdv_q && !tst_q) begin
          rdv_d = (idx_q != count_q);
        end else if (rdv_q) begin
          tst_d = 1'b1;
        end else if (absorb) begin
          cur_d = box_union(cur_q, rdata);
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      DpShift: begin
        // idx points at the removed slot; read idx+1 then write idx
        raddr = IdxBits'(idx_q + 1'b1);
        if (!rdv_q) begin
          if (CntBits'(idx_q + 1'b1) >= count_q) begin
            count_d = count_q - 1'b1;
            idx_d   = '0;
          end else begin
            rdv_d = 1'b1;
          end
        end else begin
          we    = 1'b1;
          wdata = rdata;
          idx_d = idx_q + 1'b1;
        end
      end
      DpAppend: begin
        raddr = IdxBits'(MaxRects - 1);
        if (count_q < CntBits'(MaxRects)) begin
          we      = 1'b1;
          waddr   = count_q[IdxBits-1:0];
          wdata   = cur_q;
          count_d = count_q + 1'b1;
        end else if (!rdv_q) begin
          rdv_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = IdxBits'(MaxRects - 1);
          wdata = box_union(rdata, cur_q);
          ovf_d = 1'b1;
        end
      end
      DpUnion: begin
        if (!rdv_q) begin
          rdv_d = (idx_q != count_q);
          // rewind for the emit pass
          if (idx_q == count_q) begin
            idx_d = '0;
          end
        end else begin
          all_d = box_union(all_q, rdata);
          idx_d = idx_q + 1'b1;
        end
      end
      DpEmit: begin
        if (!rdv_q) begin
          rdv_d = 1'b1;
        end else if (cmd_i.take) begin
          idx_d = idx_q + 1'b1;
        end else begin
          // output register busy, keep the fetched entry
          rdv_d = 1'b1;
        end
      end
      DpIdle: begin
        idx_d = '0;
        all_d = (in_item_i.command == CmdRead) ? '0 : all_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      rdv_q   <= 1'b0;
      tst_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      rdv_q   <= rdv_d;
      tst_q   <= tst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    all_q <= all_d;
  end

  assign sts_o.absorb     = tst_q && absorb;
  assign sts_o.idx_at_end = (idx_q == count_q) && !rdv_q && !tst_q;
  assign sts_o.shift_done = !rdv_q && (CntBits'(idx_q + 1'b1) >= count_q);
  assign sts_o.rd_valid   = rdv_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.emit_last  = (CntBits'(idx_q + 1'b1) == count_q);
  assign sts_o.full       = (count_q >= CntBits'(MaxRects));

  assign out_item_o.rect_left    = sts_o.empty ? '0 : rdata.l;
  assign out_item_o.rect_top     = sts_o.empty ? '0 : rdata.t;
  assign out_item_o.rect_right   = sts_o.empty ? '0 : rdata.r;
  assign out_item_o.rect_bottom  = sts_o.empty ? '0 : rdata.b;
  assign out_item_o.entry_valid  = !sts_o.empty;
  assign out_item_o.last_entry   = sts_o.empty || sts_o.emit_last;
  assign out_item_o.union_left   = all_q.l;
  assign out_item_o.union_top    = all_q.t;
  assign out_item_o.union_right  = all_q.r;
  assign out_item_o.union_bottom = all_q.b;
  assign out_item_o.overflowed   = ovf_q;
endmodule

### src/drc_ctrl.sv
// drc_ctrl: sequencer for clear, add (scan, remove, append) and read-out
// depends on drc_pkg
module drc_ctrl
  import drc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_ready_o,
  output logic     out_load_o,
  input  logic     out_free_i,
  input  dp_sts_t  sts_i,
  output dp_cmd_t  cmd_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StShift = 3'd3;
  localparam logic [2:0] StApp   = 3'd4;
  localparam logic [2:0] StUnion = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DpIdle;
    cmd_o.take = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (in_item_i.command)
            CmdClear: cmd_o.op = DpClear;
            CmdAdd: begin
              // rectangle captured on the accepting edge
              cmd_o.op = DpLoad;
              state_d  = StScan;
            end
            CmdRead:  state_d  = StUnion;
            default:  cmd_o.op = DpIdle;
          endcase
        end
      end
      StScan: begin
        cmd_o.op = DpScan;
        if (sts_i.idx_at_end) begin
          state_d = StApp;
        end else if (sts_i.absorb) begin
          state_d = StShift;
        end
      end
      StShift: begin
        cmd_o.op = DpShift;
        if (sts_i.shift_done) begin
          state_d = StScan;
        end
      end
      StApp: begin
        cmd_o.op = DpAppend;
        // full-list tail merge waits for the registered tail read
        if (!sts_i.full || sts_i.rd_valid) begin
          state_d = StIdle;
        end
      end
      StUnion: begin
        cmd_o.op = DpUnion;
        if (sts_i.idx_at_end) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.empty) begin
          out_load_o = out_free_i;
          if (out_free_i) begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.op = DpEmit;
          if (sts_i.rd_valid && out_free_i) begin
            cmd_o.take = 1'b1;
            out_load_o = 1'b1;
            if (sts_i.emit_last) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### src/dirty_rect_coalescer.sv
// dirty_rect_coalescer: top level joining the sequencer, datapath and output register
// depends on drc_pkg, drc_ctrl, drc_datapath
//
// usage
//   - in channel (in_valid_i/in_ready_o) carries one command transaction:
//     clear, add a rectangle, or read out the list; code 3 is dropped
//   - out channel (out_valid_o/out_ready_i) returns one transaction per
//     stored entry on a read, or one empty marker when the list is empty
//   - cfg_we_i writes the merge waste limit; the user writes it only while
//     the block is idle, and the block itself does not enforce this
// sequence
//   - clear empties the list; add scans every stored entry, removes each merged
//     one by shifting entries down and rescans, paced by the single ram read port
//   - read does a union pass over all entries, then emits each entry
// reset
//   - list and overflow flag cleared, waste limit zero
// stalls
//   - a result waits in the output register; the sequencer holds on it
module dirty_rect_coalescer
  import drc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [WasteBits-1:0] cfg_wdata_i
);
  logic [WasteBits-1:0] limit_q;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  out_item_t            dp_out;
  logic                 out_load;
  logic                 out_free;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  // output register frees when empty or being taken this cycle
  assign out_free = !out_valid_q || out_ready_i;

  drc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .in_ready_o(in_ready_o),
    .out_load_o(out_load),
    .out_free_i(out_free),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  drc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .waste_limit_i(limit_q),
    .in_item_i    (in_item_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_item_o   (dp_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= dp_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // results only appear while the sequencer is busy with a read
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !in_ready_o)
    else $error("result loaded while idle");
  // the output register never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output overwritten");
  // a loaded result is presented in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded result not shown");
`endif
endmodule
